[hdl/mvt_pkg.sv]
package mvt_pkg;

  localparam int unsigned NUM_ELEMS  = 4;
  localparam int unsigned ELEM_W     = 32;
  localparam int unsigned PROD_W     = 2 * ELEM_W;
  localparam int unsigned PAIR_W     = PROD_W + 1;
  localparam int unsigned SUM_W      = PROD_W + 2;
  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned MAT_ELEMS  = NUM_ELEMS * NUM_ELEMS;

  typedef enum logic {
    ACT_COL_VEC = 1'b0,
    ACT_ROW_VEC = 1'b1
  } action_e;

  typedef struct packed {
    action_e                  action;
    logic signed [ELEM_W-1:0] elem_0;
    logic signed [ELEM_W-1:0] elem_1;
    logic signed [ELEM_W-1:0] elem_2;
    logic signed [ELEM_W-1:0] elem_3;
  } in_req_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] res_0;
    logic signed [ELEM_W-1:0] res_1;
    logic signed [ELEM_W-1:0] res_2;
    logic signed [ELEM_W-1:0] res_3;
    logic                     saturated;
  } out_req_t;

  typedef struct packed {
    logic mul;
    logic pair;
    logic sum;
    logic sat;
  } stage_en_t;

endpackage

[hdl/mvt_dot4.sv]
module mvt_dot4 #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                                    clk_i,
  input  mvt_pkg::stage_en_t                                      en_i,
  input  logic [mvt_pkg::NUM_ELEMS-1:0][mvt_pkg::ELEM_W-1:0]      a_i,
  input  logic [mvt_pkg::NUM_ELEMS-1:0][mvt_pkg::ELEM_W-1:0]      b_i,
  output logic signed [mvt_pkg::ELEM_W-1:0]                       res_o,
  output logic                                                    sat_o
);

  localparam logic signed [mvt_pkg::SUM_W-1:0] SatMax =
    {{(mvt_pkg::SUM_W - mvt_pkg::ELEM_W + 1){1'b0}}, {(mvt_pkg::ELEM_W - 1){1'b1}}};
  localparam logic signed [mvt_pkg::SUM_W-1:0] SatMin =
    {{(mvt_pkg::SUM_W - mvt_pkg::ELEM_W + 1){1'b1}}, {(mvt_pkg::ELEM_W - 1){1'b0}}};

  logic signed [mvt_pkg::PROD_W-1:0] prod_q [mvt_pkg::NUM_ELEMS];
  logic signed [mvt_pkg::PAIR_W-1:0] pair_q [2];
  logic signed [mvt_pkg::SUM_W-1:0]  sum_q;
  logic signed [mvt_pkg::SUM_W-1:0]  shifted;
  logic signed [mvt_pkg::ELEM_W-1:0] res_d, res_q;
  logic                              sat_d, sat_q;

  // stage 1: full-width products
  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      for (int k = 0; k < mvt_pkg::NUM_ELEMS; k++) begin
        prod_q[k] <= $signed({{mvt_pkg::ELEM_W{a_i[k][mvt_pkg::ELEM_W-1]}}, a_i[k]})
                   * $signed({{mvt_pkg::ELEM_W{b_i[k][mvt_pkg::ELEM_W-1]}}, b_i[k]});
      end
    end
  end

  // stage 2: pairwise sums
  always_ff @(posedge clk_i) begin
    if (en_i.pair) begin
      for (int j = 0; j < 2; j++) begin
        pair_q[j] <= $signed({prod_q[2*j][mvt_pkg::PROD_W-1], prod_q[2*j]})
                   + $signed({prod_q[2*j+1][mvt_pkg::PROD_W-1], prod_q[2*j+1]});
      end
    end
  end

  // stage 3: exact total
  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      sum_q <= $signed({pair_q[0][mvt_pkg::PAIR_W-1], pair_q[0]})
             + $signed({pair_q[1][mvt_pkg::PAIR_W-1], pair_q[1]});
    end
  end

  // stage 4: floor shift and clamp
  always_comb begin
    shifted = sum_q >>> FRAC_BITS;
    sat_d   = 1'b1;
    priority if (shifted > SatMax) begin
      res_d = SatMax[mvt_pkg::ELEM_W-1:0];
    end else if (shifted < SatMin) begin
      res_d = SatMin[mvt_pkg::ELEM_W-1:0];
    end else begin
      res_d = shifted[mvt_pkg::ELEM_W-1:0];
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sat) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

[hdl/matrix_vector_transform.sv]
// Pipeline: from request acceptance to result valid a request passes through the stages
// multiply, pair add, final add, shift and clamp, each stage a register.
// Throughput: one request per cycle; a stall on the output holds only the
// stages that are full, empty stages keep taking requests.
// Reset: pipeline empty, matrix set to identity.
module matrix_vector_transform #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [mvt_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [mvt_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  mvt_pkg::in_req_t                      in_req_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output mvt_pkg::out_req_t                     out_req_o
);

  localparam logic [mvt_pkg::ELEM_W-1:0] One = mvt_pkg::ELEM_W'(1) << FRAC_BITS;

  logic [mvt_pkg::ELEM_W-1:0] mat_q [mvt_pkg::MAT_ELEMS];

  logic [mvt_pkg::NUM_ELEMS-1:0][mvt_pkg::ELEM_W-1:0] vec;
  logic [mvt_pkg::NUM_ELEMS-1:0][mvt_pkg::NUM_ELEMS-1:0][mvt_pkg::ELEM_W-1:0] row;
  logic signed [mvt_pkg::ELEM_W-1:0] res [mvt_pkg::NUM_ELEMS];
  logic [mvt_pkg::NUM_ELEMS-1:0]     sat;

  mvt_pkg::stage_en_t en;
  logic v1_q, v2_q, v3_q, v4_q;

  // matrix registers, identity after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < mvt_pkg::NUM_ELEMS; r++) begin
        for (int c = 0; c < mvt_pkg::NUM_ELEMS; c++) begin
          mat_q[r * mvt_pkg::NUM_ELEMS + c] <= (r == c) ? One : '0;
        end
      end
    end else if (cfg_we_i) begin
      mat_q[{cfg_idx_i, 1'b0}] <= cfg_data_i[mvt_pkg::ELEM_W-1:0];
      mat_q[{cfg_idx_i, 1'b1}] <= cfg_data_i[mvt_pkg::CFG_DATA_W-1:mvt_pkg::ELEM_W];
    end
  end

  // pipeline control
  always_comb begin
    en.sat  = !v4_q || !out_stall_i;
    en.sum  = !v3_q || en.sat;
    en.pair = !v2_q || en.sum;
    en.mul  = !v1_q || en.pair;
  end

  assign in_stall_o = !en.mul;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en.mul)  v1_q <= in_valid_i;
      if (en.pair) v2_q <= v1_q;
      if (en.sum)  v3_q <= v2_q;
      if (en.sat)  v4_q <= v3_q;
    end
  end

  // operand selection: row of M for M*v, column of M for v*M
  always_comb begin
    vec[0] = in_req_i.elem_0;
    vec[1] = in_req_i.elem_1;
    vec[2] = in_req_i.elem_2;
    vec[3] = in_req_i.elem_3;
    for (int i = 0; i < mvt_pkg::NUM_ELEMS; i++) begin
      for (int k = 0; k < mvt_pkg::NUM_ELEMS; k++) begin
        unique case (in_req_i.action)
          mvt_pkg::ACT_COL_VEC: row[i][k] = mat_q[i * mvt_pkg::NUM_ELEMS + k];
          mvt_pkg::ACT_ROW_VEC: row[i][k] = mat_q[k * mvt_pkg::NUM_ELEMS + i];
          default:              row[i][k] = mat_q[i * mvt_pkg::NUM_ELEMS + k];
        endcase
      end
    end
  end

  for (genvar g = 0; g < mvt_pkg::NUM_ELEMS; g++) begin : g_lane
    mvt_dot4 #(
      .FRAC_BITS(FRAC_BITS)
    ) u_dot4 (
      .clk_i(clk_i),
      .en_i (en),
      .a_i  (row[g]),
      .b_i  (vec),
      .res_o(res[g]),
      .sat_o(sat[g])
    );
  end

  assign out_valid_o         = v4_q;
  assign out_req_o.res_0     = res[0];
  assign out_req_o.res_1     = res[1];
  assign out_req_o.res_2     = res[2];
  assign out_req_o.res_3     = res[3];
  assign out_req_o.saturated = |sat;

endmodule

[sim/tb_top.sv]
module tb_top;

  localparam int FRAC = 16;
  localparam int LIMIT = 400000;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  typedef struct {
    logic              load;
    logic [31:0]       fill;
    mvt_pkg::in_req_t  req;
    logic              typed;
    mvt_pkg::out_req_t want;
  } dir_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [mvt_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [mvt_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           in_valid;
  logic                           in_stall;
  mvt_pkg::in_req_t               in_req;
  logic                           out_valid;
  logic                           out_stall;
  mvt_pkg::out_req_t              out_req;

  logic signed [31:0] mat_el [16];
  logic [31:0]        mat_vals [16];
  mvt_pkg::out_req_t  pending_results [$];
  dir_row_t           dir_tab [$];
  mvt_pkg::out_req_t  table_want;
  mvt_pkg::out_req_t  want;
  logic               table_on;
  int                 mismatches;
  int                 cycles;
  int                 send_pct;
  int                 rcv_pct;
  int                 hold_left;
  int                 mode;

  matrix_vector_transform #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_req_o  (out_req)
  );

  always #6 clk = ~clk;

  function automatic mvt_pkg::out_req_t transform_vec(mvt_pkg::in_req_t r);
    logic signed [31:0] v [4];
    logic signed [31:0] res [4];
    logic signed [31:0] m;
    logic signed [63:0] prod;
    logic signed [65:0] acc;
    logic signed [65:0] sh;
    logic               sat;
    mvt_pkg::out_req_t  o;
    v[0] = r.elem_0;
    v[1] = r.elem_1;
    v[2] = r.elem_2;
    v[3] = r.elem_3;
    sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        m = (r.action == mvt_pkg::ACT_ROW_VEC) ? mat_el[k*4+i] : mat_el[i*4+k];
        prod = m * v[k];
        acc = acc + prod;
      end
      sh = acc >>> FRAC;
      if (sh > 66'sd2147483647) begin
        res[i] = Q_MAX;
        sat = 1'b1;
      end else if (sh < -66'sd2147483648) begin
        res[i] = Q_MIN;
        sat = 1'b1;
      end else begin
        res[i] = sh[31:0];
      end
    end
    o.res_0 = res[0];
    o.res_1 = res[1];
    o.res_2 = res[2];
    o.res_3 = res[3];
    o.saturated = sat;
    return o;
  endfunction

  function automatic mvt_pkg::in_req_t mk_vec(mvt_pkg::action_e a, logic [31:0] x,
                                              logic [31:0] y, logic [31:0] z,
                                              logic [31:0] w);
    mvt_pkg::in_req_t r;
    r.action = a;
    r.elem_0 = x;
    r.elem_1 = y;
    r.elem_2 = z;
    r.elem_3 = w;
    return r;
  endfunction

  function automatic mvt_pkg::out_req_t mk_res(logic [31:0] x, logic [31:0] y,
                                               logic [31:0] z, logic [31:0] w, logic sat);
    mvt_pkg::out_req_t o;
    o.res_0 = x;
    o.res_1 = y;
    o.res_2 = z;
    o.res_3 = w;
    o.saturated = sat;
    return o;
  endfunction

  function automatic mvt_pkg::out_req_t same_res(mvt_pkg::in_req_t r);
    return mk_res(r.elem_0, r.elem_1, r.elem_2, r.elem_3, 1'b0);
  endfunction

  function automatic logic [31:0] pick_val();
    case ($urandom_range(11))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return Q_ONE;
      4: return '1;
      5, 6: return $urandom();
      default: return 32'($urandom_range(20'hFFFFF)) - 32'h0008_0000;
    endcase
  endfunction

  task automatic add_row(logic load, logic [31:0] fill, mvt_pkg::in_req_t r, logic typed,
                         mvt_pkg::out_req_t w);
    dir_row_t row;
    row.load = load;
    row.fill = fill;
    row.req = r;
    row.typed = typed;
    row.want = w;
    dir_tab.push_back(row);
  endtask

  task automatic check_field(string fld, logic [31:0] w, logic [31:0] g);
    if (w !== g) begin
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, fld, w, g);
    end
  endtask

  task automatic send_req(mvt_pkg::in_req_t r, logic typed, mvt_pkg::out_req_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    table_on = typed;
    table_want = w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_matrix();
    for (int n = 0; n < mvt_pkg::NUM_REGS; n++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_idx <= mvt_pkg::CFG_IDX_W'(n);
      cfg_data <= {mat_vals[2*n+1], mat_vals[2*n]};
      mat_el[2*n] = mat_vals[2*n];
      mat_el[2*n+1] = mat_vals[2*n+1];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: random stall, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result %h", $time, out_req);
        end else begin
          want = pending_results.pop_front();
          check_field("res_0", want.res_0, out_req.res_0);
          check_field("res_1", want.res_1, out_req.res_1);
          check_field("res_2", want.res_2, out_req.res_2);
          check_field("res_3", want.res_3, out_req.res_3);
          check_field("saturated", 32'(want.saturated), 32'(out_req.saturated));
        end
      end
      if (in_valid && !in_stall) begin
        pending_results.push_back(table_on ? table_want : transform_vec(in_req));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_req = '0;
    out_stall = 1'b0;
    table_on = 1'b0;
    table_want = '0;
    mismatches = 0;
    cycles = 0;
    hold_left = 0;
    send_pct = 24;
    rcv_pct = 83;
    for (int e = 0; e < 16; e++) begin
      mat_el[e] = (e % 5 == 0) ? Q_ONE : '0;
    end

    // identity after reset
    add_row(1'b0, '0, mk_vec(mvt_pkg::ACT_COL_VEC, 0, 0, 0, 0), 1'b1, '0);
    add_row(1'b0, '0, mk_vec(mvt_pkg::ACT_COL_VEC, 32'h0001_0000, 32'h0002_0000,
                             32'hFFFD_0000, 32'h0001_0000), 1'b1, '0);
    add_row(1'b0, '0, mk_vec(mvt_pkg::ACT_COL_VEC, Q_MAX, Q_MIN, Q_MAX, Q_MIN), 1'b1, '0);
    add_row(1'b0, '0, mk_vec(mvt_pkg::ACT_ROW_VEC, Q_MIN, Q_MAX, '1, 32'h1), 1'b1, '0);
    add_row(1'b0, '0, mk_vec(mvt_pkg::ACT_ROW_VEC, Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1'b1, '0);
    add_row(1'b0, '0, mk_vec(mvt_pkg::ACT_COL_VEC, '1, '1, '1, '1), 1'b1, '0);
    add_row(1'b0, '0, mk_vec(mvt_pkg::ACT_COL_VEC, Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b1, '0);
    add_row(1'b0, '0, mk_vec(mvt_pkg::ACT_ROW_VEC, 32'h5555_5555, 32'hAAAA_AAAA,
                             32'h0F0F_0F0F, 32'hF0F0_F0F0), 1'b1, '0);
    foreach (dir_tab[i]) dir_tab[i].want = same_res(dir_tab[i].req);
    // every element at the positive extreme
    add_row(1'b1, Q_MAX, mk_vec(mvt_pkg::ACT_COL_VEC, Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1'b1,
            mk_res(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
    add_row(1'b0, '0, mk_vec(mvt_pkg::ACT_ROW_VEC, Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b1,
            mk_res(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1));
    add_row(1'b0, '0, mk_vec(mvt_pkg::ACT_COL_VEC, 0, 0, 0, 0), 1'b1,
            mk_res(0, 0, 0, 0, 1'b0));
    add_row(1'b0, '0, mk_vec(mvt_pkg::ACT_ROW_VEC, 32'h1, 0, 0, 0), 1'b1,
            mk_res(32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h7FFF, 1'b0));
    // every element at the negative extreme
    add_row(1'b1, Q_MIN, mk_vec(mvt_pkg::ACT_COL_VEC, Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b1,
            mk_res(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
    add_row(1'b0, '0, mk_vec(mvt_pkg::ACT_ROW_VEC, Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1'b1,
            mk_res(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1));
    add_row(1'b0, '0, mk_vec(mvt_pkg::ACT_COL_VEC, Q_MAX, Q_MIN, 0, 0), 1'b1,
            mk_res(32'h8000, 32'h8000, 32'h8000, 32'h8000, 1'b0));
    add_row(1'b0, '0, mk_vec(mvt_pkg::ACT_ROW_VEC, '1, '1, '1, '1), 1'b1,
            mk_res(32'h2_0000, 32'h2_0000, 32'h2_0000, 32'h2_0000, 1'b0));
    add_row(1'b1, '0, mk_vec(mvt_pkg::ACT_COL_VEC, Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1'b1,
            mk_res(0, 0, 0, 0, 1'b0));
    add_row(1'b0, '0, mk_vec(mvt_pkg::ACT_ROW_VEC, Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b1,
            mk_res(0, 0, 0, 0, 1'b0));
    add_row(1'b1, Q_ONE, mk_vec(mvt_pkg::ACT_COL_VEC, 32'h1, 32'h2, 32'h3, 32'h4), 1'b1,
            mk_res(32'hA, 32'hA, 32'hA, 32'hA, 1'b0));
    add_row(1'b0, '0, mk_vec(mvt_pkg::ACT_ROW_VEC, '1, '1, '1, '1), 1'b1,
            mk_res(32'hFFFF_FFFC, 32'hFFFF_FFFC, 32'hFFFF_FFFC, 32'hFFFF_FFFC, 1'b0));
    // shift rounds toward minus infinity
    add_row(1'b1, 32'h1, mk_vec(mvt_pkg::ACT_COL_VEC, '1, 0, 0, 0), 1'b1,
            mk_res('1, '1, '1, '1, 1'b0));
    add_row(1'b0, '0, mk_vec(mvt_pkg::ACT_ROW_VEC, 32'h1, 32'h1, 32'h1, 32'h1), 1'b1,
            mk_res(0, 0, 0, 0, 1'b0));
    add_row(1'b0, '0, mk_vec(mvt_pkg::ACT_COL_VEC, Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1'b1,
            mk_res(32'h1_FFFF, 32'h1_FFFF, 32'h1_FFFF, 32'h1_FFFF, 1'b0));
    add_row(1'b0, '0, mk_vec(mvt_pkg::ACT_COL_VEC, 32'h0001_2345, 32'hFFFE_8000,
                             32'h7FFF_0000, 32'h3), 1'b0, '0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].load) begin
        drain();
        for (int e = 0; e < 16; e++) mat_vals[e] = dir_tab[i].fill;
        write_matrix();
      end
      send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      for (int blk = 0; blk < 7; blk++) begin
        drain();
        if (blk == 0) begin
          send_pct = (ph == 0) ? 24 : (ph == 1) ? 83 : 0;
          rcv_pct = (ph == 0) ? 83 : (ph == 1) ? 24 : 0;
        end
        if (ph == 2 && blk == 3) hold_left = 60;
        mode = $urandom_range(2);
        for (int e = 0; e < 16; e++) begin
          mat_vals[e] = (mode == 0) ? 32'($urandom_range(18'h3FFFF)) - 32'h0002_0000
                                    : pick_val();
        end
        write_matrix();
        repeat (95) begin
          send_req(mk_vec(mvt_pkg::action_e'($urandom_range(1)), pick_val(), pick_val(),
                          pick_val(), pick_val()), 1'b0, '0);
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
hdl/mvt_pkg.sv
hdl/mvt_dot4.sv
hdl/matrix_vector_transform.sv
sim/tb_top.sv
